[rtl/bbo_pkg.sv]
// ----------------------------------------------------------------------------
// bbo_pkg
// Shared types and constants for the bounding box outline overlay.
// ----------------------------------------------------------------------------
package bbo_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_BOXES_DEF  = 12;
    localparam int COORD_BITS_DEF = 11;

    // Fixed field widths
    localparam int BOX_IDX_W = 4;
    localparam int BOX_CNT_W = 4;
    localparam int PIX_W     = 16;

    // Command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // Outline color (white in RGB565)
    localparam logic [PIX_W-1:0] EDGE_COLOR = 16'hFFFF;

    // Per-lane control from the pipeline control
    typedef struct packed {
        logic load;     // write this lane's box entry
        logic advance;  // capture compare flags into the compare stage
    } bbo_lane_ctrl_t;

    // Registered compare flags of one lane
    typedef struct packed {
        logic h_hit;    // on a horizontal edge
        logic v_hit;    // on a vertical edge
    } bbo_lane_flags_t;

endpackage

[rtl/bbo_box_lane.sv]
// ----------------------------------------------------------------------------
// bbo_box_lane
// One box slot: holds the box coordinates and registers the edge compare
// of the pixel in the input stage against this box.
// ----------------------------------------------------------------------------
module bbo_box_lane #(
    parameter int COORD_BITS = bbo_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  bbo_pkg::bbo_lane_ctrl_t       ctrl,
    input  logic [COORD_BITS-1:0]         box_left,
    input  logic [COORD_BITS-1:0]         box_top,
    input  logic [COORD_BITS-1:0]         box_right,
    input  logic [COORD_BITS-1:0]         box_bottom,
    input  logic [COORD_BITS-1:0]         pix_x,
    input  logic [COORD_BITS-1:0]         pix_y,
    output bbo_pkg::bbo_lane_flags_t      flags
);
    import bbo_pkg::*;

    localparam int E = COORD_BITS + 1;
    localparam logic [E-1:0] ONE = E'(1);
    localparam logic [E-1:0] TWO = E'(2);

    logic [COORD_BITS-1:0] left_reg;
    logic [COORD_BITS-1:0] top_reg;
    logic [COORD_BITS-1:0] right_reg;
    logic [COORD_BITS-1:0] bottom_reg;

    logic [E-1:0] xe;
    logic [E-1:0] ye;
    logic [E-1:0] left_e;
    logic [E-1:0] top_e;
    logic [E-1:0] right_e;
    logic [E-1:0] bottom_e;

    logic row_match;
    logic x_inside;
    logic y_inside;
    logic col_match;

    bbo_lane_flags_t flags_reg;
    bbo_lane_flags_t flags_next;

    // Box storage; no reset, an entry is defined once loaded
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            left_reg   <= box_left;
            top_reg    <= box_top;
            right_reg  <= box_right;
            bottom_reg <= box_bottom;
        end
    end

    // Extend by one bit so that +1 and +2 never wrap
    assign xe       = {1'b0, pix_x};
    assign ye       = {1'b0, pix_y};
    assign left_e   = {1'b0, left_reg};
    assign top_e    = {1'b0, top_reg};
    assign right_e  = {1'b0, right_reg};
    assign bottom_e = {1'b0, bottom_reg};

    always_comb
    begin
        row_match = (ye == top_e) || (ye == top_e + ONE) ||
                    (ye == bottom_e) || (ye == bottom_e + ONE);
        x_inside  = (xe >= left_e) && (xe < right_e);
        y_inside  = (ye > top_e) && (ye < bottom_e);
        col_match = (xe == left_e) || (xe == left_e + ONE) ||
                    (xe + TWO == right_e) || (xe + ONE == right_e);
        flags_next.h_hit = row_match && x_inside;
        flags_next.v_hit = y_inside && col_match;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule

[rtl/bounding_box_overlay.sv]
// ----------------------------------------------------------------------------
// bounding_box_overlay
// Draws two-pixel white rectangle outlines over an RGB565 pixel stream.
// Each input transaction either loads one box (cmd low) into a slot of the
// box table or carries one pixel (cmd high) with its whole-frame position;
// every pixel transaction yields exactly one output transaction, in order,
// replaced by white with on_edge set when it lies on the outline of any of
// the first box_count slots. Load transactions yield no output; a load to a
// slot at or above MAX_BOXES is dropped. The block takes one transaction per
// clock unless in_stall is high; a pixel passes the input stage, the per-box
// compare stage and the output register merging all slots' compare flags.
// Every active slot must be loaded before a pixel uses it. box_count must be
// written through the config port only while no pixel is in flight; the
// block does not enforce this. Values above MAX_BOXES mean all slots.
// ----------------------------------------------------------------------------
module bounding_box_overlay #(
    parameter int MAX_BOXES  = bbo_pkg::MAX_BOXES_DEF,
    parameter int COORD_BITS = bbo_pkg::COORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,

    // Config write channel (box_count)
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bbo_pkg::BOX_CNT_W-1:0]  cfg_data,

    // Input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           cmd,
    input  logic [bbo_pkg::BOX_IDX_W-1:0]  box_index,
    input  logic [COORD_BITS-1:0]          box_left,
    input  logic [COORD_BITS-1:0]          box_top,
    input  logic [COORD_BITS-1:0]          box_right,
    input  logic [COORD_BITS-1:0]          box_bottom,
    input  logic [COORD_BITS-1:0]          pixel_x,
    input  logic [COORD_BITS-1:0]          pixel_y,
    input  logic [bbo_pkg::PIX_W-1:0]      pixel_in,

    // Output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [bbo_pkg::PIX_W-1:0]      pixel_out,
    output logic                           on_edge
);
    import bbo_pkg::*;

    logic [BOX_CNT_W-1:0]  box_count_reg;

    // Input stage
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic [COORD_BITS-1:0] s1_x_reg;
    logic [COORD_BITS-1:0] s1_y_reg;
    logic [PIX_W-1:0]      s1_pix_reg;

    // Compare stage (flags live in the lanes)
    logic                  s2_valid_reg;
    logic [PIX_W-1:0]      s2_pix_reg;

    // Output register
    logic                  out_valid_reg;
    logic [PIX_W-1:0]      pixel_out_reg;
    logic                  on_edge_reg;

    logic s1_open;
    logic s2_open;
    logic s3_open;
    logic in_accept;
    logic load_accept;
    logic hit;

    logic [MAX_BOXES-1:0] active;
    logic [MAX_BOXES-1:0] edge_vec;

    // ------------------------------------------------------------------
    // Config register: always ready; the user must see that it is only written while idle (not enforced)
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            box_count_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Flow control: a stage opens when it is empty or its contents move on
    // ------------------------------------------------------------------
    assign s3_open     = !out_valid_reg || !out_stall;
    assign s2_open     = !s2_valid_reg || s3_open;
    assign s1_open     = !s1_valid_reg || s2_open;
    assign in_stall    = !s1_open;
    assign in_accept   = in_valid && !in_stall;
    assign load_accept = in_accept && (cmd == CMD_LOAD);

    // Only pixels enter the pipeline; loads finish at acceptance
    assign s1_valid_next = in_accept && (cmd == CMD_PIXEL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_open)
            begin
                s1_valid_reg <= s1_valid_next;
            end
            if (s2_open)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_open)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Payload registers: advance with their stage, hold otherwise
    always_ff @(posedge clk)
    begin
        if (s1_open)
        begin
            s1_x_reg   <= pixel_x;
            s1_y_reg   <= pixel_y;
            s1_pix_reg <= pixel_in;
        end
        if (s2_open)
        begin
            s2_pix_reg <= s1_pix_reg;
        end
        if (s3_open)
        begin
            pixel_out_reg <= hit ? EDGE_COLOR : s2_pix_reg;
            on_edge_reg   <= hit;
        end
    end

    // ------------------------------------------------------------------
    // Box lanes: one per slot, each compares the input-stage pixel.
    // A load accepted in the same cycle as a pixel leaves the input stage
    // lands at that edge, so the pixel sees the table as it was before.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < MAX_BOXES; i++)
    begin : g_lane
        bbo_lane_ctrl_t  lane_ctrl;
        bbo_lane_flags_t lane_flags;

        assign lane_ctrl.load    = load_accept && (32'(box_index) == i);
        assign lane_ctrl.advance = s2_open;

        bbo_box_lane #(
            .COORD_BITS (COORD_BITS)
        ) u_lane (
            .clk        (clk),
            .ctrl       (lane_ctrl),
            .box_left   (box_left),
            .box_top    (box_top),
            .box_right  (box_right),
            .box_bottom (box_bottom),
            .pix_x      (s1_x_reg),
            .pix_y      (s1_y_reg),
            .flags      (lane_flags)
        );

        // Slot is drawn only below box_count; counts past the table use all
        assign active[i]   = (32'(box_count_reg) > i);
        assign edge_vec[i] = lane_flags.h_hit || lane_flags.v_hit;
    end

    assign hit = |(edge_vec & active);

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign on_edge   = on_edge_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef ASSERT_OFF
    // Input backs up only when every stage is full and the sink stalls
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s2_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with room in the pipeline");

    // A pixel in the input stage with room ahead moves into the compare stage
    a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_open) |=> s2_valid_reg)
        else $error("pixel dropped between input and compare stage");

    // A flagged result always carries the outline color
    a_edge_color: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && on_edge) |-> (pixel_out == EDGE_COLOR))
        else $error("edge flag without outline color");

    // A compare-stage pixel leaves when the output register opens
    a_s2_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s3_open) |=> out_valid_reg)
        else $error("pixel dropped between compare stage and output");
`endif

endmodule
